[hdl/rca_pkg.sv]
// shared types and codes of the reference-counted id allocator
package rca_pkg;

  localparam int unsigned IdW    = 11;
  localparam int unsigned CountW = 16;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StatW  = 2;

  localparam logic [KindW-1:0] KIND_ALLOC  = 3'd0;
  localparam logic [KindW-1:0] KIND_INC    = 3'd1;
  localparam logic [KindW-1:0] KIND_DEC    = 3'd2;
  localparam logic [KindW-1:0] KIND_RENAME = 3'd3;
  localparam logic [KindW-1:0] KIND_LOOKUP = 3'd4;

  localparam logic [StatW-1:0] STAT_OK      = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL    = 2'd1;
  localparam logic [StatW-1:0] STAT_MISSING = 2'd2;
  localparam logic [StatW-1:0] STAT_IN_USE  = 2'd3;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_LATCH,
    CELL_ALLOC,
    CELL_SET_CNT,
    CELL_CLEAR,
    CELL_RENAME
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [IdW-1:0]    id;
    logic [CountW-1:0] count;
  } cell_cmd_t;

endpackage

[hdl/refcounted_id_allocator.sv]
// Reference-counted id allocator: a row of TABLE_ENTRIES slot cells searched by a
// broadcast key, with a free-slot chain running from slot 0 upward. One request is
// handled at a time. Increment, decrement and lookup pass the search, execute and done
// states; replace does the same, its execute state searching for the new id.
// Allocate tries candidate ids one after another (LFSR step, reciprocal multiply,
// remainder, table search), up to 65535 candidates; a full table skips to done.
// The result register frees the input side while a result waits on the output.
module refcounted_id_allocator #(
  parameter int unsigned MAX_ID_VALUE  = 1024,
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // kind[2:0], target_id[13:3], renamed_id[24:14], initial_count[40:25], zero fill
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], result_id[12:2], found[13], ref_count[29:14], zero fill
  output logic [31:0] m_axis_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import rca_pkg::*;

  localparam int unsigned UsedW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / MAX_ID_VALUE);
  localparam logic [15:0] MaxId = 16'(MAX_ID_VALUE);
  localparam logic [16:0] UsedLimit = 17'(MAX_ID_VALUE - 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SEARCH = 8'b0000_0010,
    ST_EXEC   = 8'b0000_0100,
    ST_STEP   = 8'b0000_1000,
    ST_MUL    = 8'b0001_0000,
    ST_SUB    = 8'b0010_0000,
    ST_CHECK  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e            state_q;
  logic [15:0]       seed_q, lfsr_q, tries_q;
  logic [UsedW-1:0]  used_q;
  logic [KindW-1:0]  kind_q;
  logic [IdW-1:0]    tid_q, nid_q;
  logic [CountW-1:0] icnt_q, cnt_q;
  logic              hit_q;
  logic [47:0]       prod_q;
  logic [16:0]       rem_q;
  logic [StatW-1:0]  res_status_q;
  logic [IdW-1:0]    res_id_q;
  logic              res_found_q;
  logic [CountW-1:0] res_cnt_q;
  logic              out_valid_q;
  logic [31:0]       out_data_q;

  logic [IdW-1:0]     key;
  cell_cmd_t          cmd;
  logic [TABLE_ENTRIES:0] free_chain;
  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [CountW-1:0]  cnt_vec [TABLE_ENTRIES];
  logic               any_hit;
  logic [CountW-1:0]  hit_cnt;
  logic [15:0]        rem_fix;
  logic [IdW-1:0]     cand;
  logic               full;
  logic               cfg_wr;
  logic [15:0]        lfsr_next;

  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rca_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (key),
      .cmd_i      (cmd),
      .free_seen_i(free_chain[g]),
      .free_seen_o(free_chain[g+1]),
      .match_o    (match_vec[g]),
      .count_o    (cnt_vec[g])
    );
  end

  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) hit_cnt = hit_cnt | cnt_vec[i];
  end
  assign any_hit = |match_vec;

  // remainder after the reciprocal estimate is below twice the modulus
  assign rem_fix = (rem_q >= {1'b0, MaxId}) ? 16'(rem_q - {1'b0, MaxId}) : rem_q[15:0];
  assign cand    = IdW'(rem_fix + 16'd1);
  assign full    = !free_chain[TABLE_ENTRIES] || (17'(used_q) >= UsedLimit);
  assign lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == 1'b0);
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == 1'b0) ? {16'd0, seed_q} : 32'd0;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    key       = tid_q;
    cmd.op    = CELL_NOP;
    cmd.id    = nid_q;
    cmd.count = icnt_q;
    unique case (state_q)
      ST_SEARCH: cmd.op = CELL_LATCH;
      ST_EXEC: begin
        key = nid_q;
        if (hit_q) begin
          case (kind_q)
            KIND_INC: begin
              cmd.op    = CELL_SET_CNT;
              cmd.count = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
            end
            KIND_DEC: begin
              cmd.op    = (cnt_q <= 16'd1) ? CELL_CLEAR : CELL_SET_CNT;
              cmd.count = cnt_q - 1'b1;
            end
            KIND_RENAME: if (nid_q != tid_q && !any_hit) cmd.op = CELL_RENAME;
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        key = cand;
        cmd.id = cand;
        if (!any_hit) cmd.op = CELL_ALLOC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= 16'd1;
      lfsr_q      <= 16'd1;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i && state_q != ST_DONE) out_valid_q <= 1'b0;
      if (cfg_wr) begin
        seed_q <= pwdata_i[15:0];
        lfsr_q <= (pwdata_i[15:0] == 16'd0) ? 16'd1 : pwdata_i[15:0];
      end
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid_i) state_q <= ST_SEARCH;
        ST_SEARCH: begin
          if (kind_q == KIND_ALLOC) state_q <= full ? ST_DONE : ST_STEP;
          else state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (hit_q && kind_q == KIND_DEC && cnt_q <= 16'd1) used_q <= used_q - 1'b1;
          state_q <= ST_DONE;
        end
        ST_STEP: begin
          lfsr_q  <= lfsr_next;
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_SUB;
        ST_SUB: state_q <= ST_CHECK;
        ST_CHECK: begin
          if (!any_hit) begin
            used_q  <= used_q + 1'b1;
            state_q <= ST_DONE;
          end else if (tries_q == 16'hFFFE) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_STEP;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        kind_q <= s_axis_tdata_i[2:0];
        tid_q  <= s_axis_tdata_i[13:3];
        nid_q  <= s_axis_tdata_i[24:14];
        icnt_q <= s_axis_tdata_i[40:25];
      end
      ST_SEARCH: begin
        hit_q   <= any_hit;
        cnt_q   <= hit_cnt;
        tries_q <= '0;
        res_status_q <= STAT_FULL;
        res_id_q     <= '0;
        res_found_q  <= 1'b0;
        res_cnt_q    <= '0;
      end
      ST_EXEC: begin
        res_id_q    <= tid_q;
        res_found_q <= hit_q;
        res_cnt_q   <= '0;
        if (!hit_q) begin
          res_status_q <= STAT_MISSING;
        end else begin
          res_status_q <= STAT_OK;
          case (kind_q)
            KIND_INC: res_cnt_q <= (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
            KIND_DEC: res_cnt_q <= (cnt_q <= 16'd1) ? '0 : cnt_q - 1'b1;
            KIND_RENAME: begin
              res_cnt_q <= cnt_q;
              if (nid_q != tid_q && any_hit) res_status_q <= STAT_IN_USE;
            end
            default: res_cnt_q <= cnt_q;
          endcase
        end
      end
      ST_MUL: prod_q <= 48'(lfsr_q) * 48'(Recip);
      ST_SUB: rem_q <= {1'b0, lfsr_q} - 17'(prod_q[47:32] * MaxId);
      ST_CHECK: begin
        tries_q <= tries_q + 1'b1;
        if (!any_hit) begin
          res_status_q <= STAT_OK;
          res_id_q     <= cand;
          res_cnt_q    <= icnt_q;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_q <= {2'b00, res_cnt_q, res_found_q, res_id_q, res_status_q};
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/rca_cell.sv]
// one table slot: id, count, valid and selection flag, with the free-slot chain
module rca_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [rca_pkg::IdW-1:0]    key_i,
  input  rca_pkg::cell_cmd_t         cmd_i,
  input  logic                       free_seen_i,
  output logic                       free_seen_o,
  output logic                       match_o,
  output logic [rca_pkg::CountW-1:0] count_o
);
  import rca_pkg::*;

  logic              valid_q;
  logic              sel_q;
  logic [IdW-1:0]    id_q;
  logic [CountW-1:0] cnt_q;
  logic              first_free;

  assign match_o     = valid_q && (id_q == key_i);
  assign count_o     = match_o ? cnt_q : '0;
  assign first_free  = !valid_q && !free_seen_i;
  assign free_seen_o = free_seen_i || !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      case (cmd_i.op)
        CELL_LATCH: sel_q <= match_o;
        CELL_ALLOC: if (first_free) valid_q <= 1'b1;
        CELL_CLEAR: if (sel_q) valid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CELL_ALLOC: begin
        if (first_free) begin
          id_q  <= cmd_i.id;
          cnt_q <= cmd_i.count;
        end
      end
      CELL_SET_CNT: if (sel_q) cnt_q <= cmd_i.count;
      CELL_RENAME:  if (sel_q) id_q <= cmd_i.id;
      default: ;
    endcase
  end

endmodule

[hdl/rca_checker.sv]
// port-level checks of the allocator, bound to the top level
module rca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o
);
  import rca_pkg::*;

  logic [StatW-1:0] st;
  assign st = m_axis_tdata_o[1:0];

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // full gives no id and no count
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == STAT_FULL |-> m_axis_tdata_o[12:2] == '0
      && m_axis_tdata_o[29:13] == '0)
    else $error("full status with id or count");

  // unknown id reports nothing found
  a_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == STAT_MISSING |-> m_axis_tdata_o[29:13] == '0)
    else $error("missing id with found or count");

  // one request at a time: no new input beat right after one was taken
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

endmodule

bind refcounted_id_allocator rca_checker u_rca_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o)
);
